/* rtl/core/tts_pkg.sv */
// shared types and constants for the timer table scheduler
`default_nettype none
package tts_pkg;
  localparam int SLOTS = 16;
  localparam int TIME_BITS = 48;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int EXP_W = TIME_BITS + 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_DEL = 2'd1, OP_RST = 2'd2, OP_PROC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_ADD = 3'd0, K_DEL = 3'd1, K_RST = 3'd2, K_FIRE = 3'd3, K_WAIT = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SNAP, S_SCAN, S_FIRE, S_MIN, S_OUT
  } state_t;

  // one write into the slot memories
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [EXP_W-1:0] expiry;
    logic             wr_ivl;
    logic [31:0]      ivl;
  } mem_wr_t;
endpackage
`default_nettype wire

/* rtl/core/tts_mem.sv */
// slot memory: expiry and interval, one write port, one registered read
`default_nettype none
module tts_mem (
  input  wire logic                    clk,
  input  wire tts_pkg::mem_wr_t        wr,
  input  wire logic [tts_pkg::IDX_W-1:0] rd_addr,
  output logic [tts_pkg::EXP_W-1:0]    rd_expiry,
  output logic [31:0]                  rd_ivl
);
  import tts_pkg::*;
  logic [EXP_W-1:0] exp_mem [SLOTS];
  logic [31:0]      ivl_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      exp_mem[wr.addr] <= wr.expiry;
      if (wr.wr_ivl) ivl_mem[wr.addr] <= wr.ivl;
    end
    rd_expiry <= exp_mem[rd_addr];
    rd_ivl    <= ivl_mem[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/core/timer_table_scheduler.sv */
// top level of the timer table scheduler
`default_nettype none
// Timer table of SLOTS entries whose expiry and interval live in a synchronous
// memory. Add, delete and reset take one transaction and give one result.
// Process walks the memory once per fired timer to find the earliest due slot,
// sending each firing from S_FIRE, then makes one pass that finds nothing due
// and one pass for the minimum expiry, after which the wait result is sent.
// All passes go through the single memory read port; a result held by the
// sink stalls the next firing or the wait result until it is taken.
// Results sit in an output register; the next transaction is taken once the
// last result of the current one has been sent.
module timer_table_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[1:0], timer_id[5:2], delay[37:6], repeat_mode[38], now_ms[86:39]
  input  wire logic [87:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // kind[2:0], slot_id[6:3], status[7], wait_ms[39:8], live_count[44:40]
  output logic [47:0]      out_tdata,
  output logic             out_tlast
);
  import tts_pkg::*;

  state_t state_r, state_nxt;
  logic [SLOTS-1:0] act_r, act_nxt, rep_r, rep_nxt, due_r, due_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  // latched transaction
  logic [1:0]  op_r;
  logic [3:0]  id_r;
  logic [31:0] dly_r;
  logic        rmode_r;
  logic [TIME_BITS-1:0] now_r;
  // scan walker: address issued, data arrives in the next cycle
  logic [IDX_W:0]   sidx_r, sidx_nxt;
  logic [IDX_W-1:0] didx_r;
  logic             dval_r, dval_nxt;
  logic             any_r, any_nxt;
  logic [EXP_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  // output register
  logic        ov_r, ov_nxt, olast_r, olast_nxt;
  logic [47:0] od_r, od_nxt;

  mem_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  logic [EXP_W-1:0] rd_expiry;
  logic [31:0]      rd_ivl;

  tts_mem u_mem (.clk, .wr, .rd_addr, .rd_expiry, .rd_ivl);

  logic [EXP_W-1:0] target, now_x, diff;
  logic [IDX_W-1:0] free_idx;
  logic             free_any, id_ok;
  logic [IDX_W-1:0] id_s;

  assign target = {1'b0, now_r} + EXP_W'(dly_r);
  assign now_x  = {1'b0, now_r};
  assign diff   = best_r - now_x;
  assign id_ok  = ({28'd0, id_r} < 32'(SLOTS));
  assign id_s   = IDX_W'(id_r);

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  function automatic logic [47:0] pack(kind_t k, logic [3:0] s, logic st,
                                       logic [31:0] w, logic [CNT_W-1:0] c);
    pack = {3'd0, 5'(c), w, st, s, 3'(k)};
  endfunction

  assign in_tready  = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = olast_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r; rep_nxt = rep_r; due_nxt = due_r; cnt_nxt = cnt_r;
    sidx_nxt = sidx_r; dval_nxt = 1'b0;
    any_nxt = any_r; best_nxt = best_r; pick_nxt = pick_r;
    ov_nxt = ov_r && !out_tready; olast_nxt = olast_r; od_nxt = od_r;
    wr = '0;
    rd_addr = sidx_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_SNAP;
      S_SNAP: begin
        // single-result operations complete here
        ov_nxt = 1'b1; olast_nxt = 1'b1;
        unique case (op_t'(op_r))
          OP_ADD: begin
            if (free_any) begin
              act_nxt[free_idx] = 1'b1; rep_nxt[free_idx] = rmode_r;
              cnt_nxt = cnt_r + 1'b1;
              wr = '{we: 1'b1, addr: free_idx, expiry: target,
                     wr_ivl: 1'b1, ivl: rmode_r ? dly_r : 32'd0};
              od_nxt = pack(K_ADD, 4'(free_idx), 1'b0, 32'd0, cnt_r + 1'b1);
            end else begin
              od_nxt = pack(K_ADD, 4'd0, 1'b1, 32'd0, cnt_r);
            end
            state_nxt = S_IDLE;
          end
          OP_DEL: begin
            if (id_ok && act_r[id_s]) begin
              act_nxt[id_s] = 1'b0; cnt_nxt = cnt_r - 1'b1;
              od_nxt = pack(K_DEL, id_r, 1'b0, 32'd0, cnt_r - 1'b1);
            end else begin
              od_nxt = pack(K_DEL, id_r, 1'b1, 32'd0, cnt_r);
            end
            state_nxt = S_IDLE;
          end
          OP_RST: begin
            if (id_ok) begin
              wr = '{we: 1'b1, addr: id_s, expiry: target,
                     wr_ivl: 1'b0, ivl: 32'd0};
              act_nxt[id_s] = 1'b1;
              cnt_nxt = act_r[id_s] ? cnt_r : cnt_r + 1'b1;
              od_nxt = pack(K_RST, id_r, 1'b0, 32'd0, cnt_nxt);
            end else begin
              od_nxt = pack(K_RST, id_r, 1'b1, 32'd0, cnt_r);
            end
            state_nxt = S_IDLE;
          end
          default: begin
            // process: clear the fired set, then the first pass picks the earliest
            ov_nxt = ov_r && !out_tready; olast_nxt = olast_r;
            due_nxt = '0; any_nxt = 1'b0; sidx_nxt = '0;
            state_nxt = S_SCAN;
          end
        endcase
      end
      S_SCAN, S_MIN: begin
        // walk all slots; S_SCAN skips slots already fired by this process
        if (sidx_r < (IDX_W+1)'(SLOTS)) begin
          dval_nxt = 1'b1;
          sidx_nxt = sidx_r + 1'b1;
        end
        if (dval_r) begin
          if (act_r[didx_r] && (state_r == S_MIN || !due_r[didx_r])
              && (!any_r || rd_expiry < best_r)) begin
            any_nxt = 1'b1; best_nxt = rd_expiry; pick_nxt = didx_r;
          end
        end
        if (!dval_r && sidx_r == (IDX_W+1)'(SLOTS)) begin
          if (state_r == S_SCAN) begin
            if (any_r && best_r <= now_x) state_nxt = S_FIRE;
            else begin
              any_nxt = 1'b0; sidx_nxt = '0; state_nxt = S_MIN;
            end
          end else state_nxt = S_OUT;
        end
      end
      S_FIRE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; olast_nxt = 1'b0;
          due_nxt[pick_r] = 1'b1;
          if (rep_r[pick_r]) begin
            wr = '{we: 1'b1, addr: pick_r,
                   expiry: now_x + EXP_W'(rd_ivl), wr_ivl: 1'b0, ivl: 32'd0};
            od_nxt = pack(K_FIRE, 4'(pick_r), 1'b0, 32'd0, cnt_r);
          end else begin
            act_nxt[pick_r] = 1'b0; cnt_nxt = cnt_r - 1'b1;
            od_nxt = pack(K_FIRE, 4'(pick_r), 1'b0, 32'd0, cnt_r - 1'b1);
          end
          any_nxt = 1'b0; sidx_nxt = '0; state_nxt = S_SCAN;
        end else rd_addr = pick_r;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; olast_nxt = 1'b1;
          od_nxt = pack(K_WAIT, 4'd0, 1'b0,
                        !any_r ? 32'hFFFF_FFFF :
                        (best_r <= now_x) ? 32'd0 :
                        (diff > EXP_W'(32'h7FFF_FFFF)) ? 32'hFFFF_FFFF : diff[31:0],
                        cnt_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // fire needs interval of pick: read it at scan end
    if (state_r == S_SCAN && state_nxt == S_FIRE) rd_addr = pick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; act_r <= '0; rep_r <= '0; cnt_r <= '0;
      ov_r <= 1'b0; dval_r <= 1'b0; due_r <= '0;
    end else begin
      state_r <= state_nxt; act_r <= act_nxt; rep_r <= rep_nxt; cnt_r <= cnt_nxt;
      ov_r <= ov_nxt; dval_r <= dval_nxt; due_r <= due_nxt;
    end
  end

  // due_r here holds slots already fired this process (excluded from rescans)
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r <= in_tdata[1:0]; id_r <= in_tdata[5:2]; dly_r <= in_tdata[37:6];
      rmode_r <= in_tdata[38]; now_r <= in_tdata[39 +: TIME_BITS];
      pick_r <= '1;
    end else pick_r <= pick_nxt;
    sidx_r <= sidx_nxt; didx_r <= rd_addr; any_r <= any_nxt; best_r <= best_nxt;
    olast_r <= olast_nxt; od_r <= od_nxt;
  end
endmodule
`default_nettype wire

/* tb/sv/tb_timer_table_scheduler.sv */
// testbench for the timer table scheduler: random transactions against a slot-table predictor
`timescale 1ns / 100ps
module tb_timer_table_scheduler;
  import tts_pkg::*;

  // one input transaction, unpacked
  typedef struct {
    op_t         op;
    logic [3:0]  id;
    logic [31:0] delay;
    logic        rep;
    logic [47:0] now;
  } timer_cmd_t;

  // one expected result transaction
  typedef struct {
    kind_t       kind;
    logic [3:0]  slot;
    logic        status;
    logic [31:0] wait_ms;
    logic [4:0]  live;
    logic        last;
  } timer_evt_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;

  timer_table_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // predictor copy of the slot table
  logic        tbl_active [SLOTS] = '{default: 1'b0};
  logic        tbl_repeat [SLOTS] = '{default: 1'b0};
  logic [48:0] tbl_expiry [SLOTS] = '{default: 49'd0};
  logic [31:0] tbl_ivl [SLOTS] = '{default: 32'd0};
  int          tbl_live = 0;

  timer_cmd_t cmd_queue[$];
  timer_evt_t evt_queue[$];
  timer_cmd_t cur_cmd;

  int  src_idle_pct;
  int  sink_idle_pct;
  bit  src_hold;
  int  errors = 0;
  int  fired_count = 0;
  int  wait_count = 0;
  int  cmd_count = 0;
  logic [47:0] sim_now;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void push_evt(kind_t k, logic [3:0] s, logic st, logic [31:0] w,
                                   logic lst);
    timer_evt_t e;
    e.kind = k;
    e.slot = s;
    e.status = st;
    e.wait_ms = w;
    e.live = tbl_live[4:0];
    e.last = lst;
    evt_queue.push_back(e);
  endfunction

  // apply one command to the table and queue the results it causes
  function automatic void predict_timers(timer_cmd_t c);
    logic [48:0] tgt;
    logic        due [SLOTS];
    logic [48:0] best;
    logic        any;
    logic [31:0] wait_val;
    int          pick;
    int          i;
    tgt = {1'b0, c.now} + {17'd0, c.delay};
    case (c.op)
      OP_ADD: begin
        pick = -1;
        for (i = 0; i < SLOTS; i++)
          if (pick < 0 && !tbl_active[i]) pick = i;
        if (pick < 0) begin
          push_evt(K_ADD, 4'd0, 1'b1, 32'd0, 1'b1);
        end else begin
          tbl_active[pick] = 1'b1;
          tbl_repeat[pick] = c.rep;
          tbl_expiry[pick] = tgt;
          tbl_ivl[pick] = c.rep ? c.delay : 32'd0;
          tbl_live++;
          push_evt(K_ADD, pick[3:0], 1'b0, 32'd0, 1'b1);
        end
      end
      OP_DEL: begin
        if (tbl_active[c.id]) begin
          tbl_active[c.id] = 1'b0;
          tbl_live--;
          push_evt(K_DEL, c.id, 1'b0, 32'd0, 1'b1);
        end else begin
          push_evt(K_DEL, c.id, 1'b1, 32'd0, 1'b1);
        end
      end
      OP_RST: begin
        tbl_expiry[c.id] = tgt;
        if (!tbl_active[c.id]) begin
          tbl_active[c.id] = 1'b1;
          tbl_live++;
        end
        push_evt(K_RST, c.id, 1'b0, 32'd0, 1'b1);
      end
      default: begin
        // snapshot the due set, then fire earliest first, lowest slot on ties
        for (i = 0; i < SLOTS; i++)
          due[i] = tbl_active[i] && tbl_expiry[i] <= {1'b0, c.now};
        forever begin
          pick = -1;
          for (i = 0; i < SLOTS; i++)
            if (due[i] && (pick < 0 || tbl_expiry[i] < tbl_expiry[pick])) pick = i;
          if (pick < 0) break;
          due[pick] = 1'b0;
          if (tbl_repeat[pick]) begin
            tbl_expiry[pick] = {1'b0, c.now} + {17'd0, tbl_ivl[pick]};
          end else begin
            tbl_active[pick] = 1'b0;
            tbl_live--;
          end
          push_evt(K_FIRE, pick[3:0], 1'b0, 32'd0, 1'b0);
        end
        any = 1'b0;
        best = '0;
        for (i = 0; i < SLOTS; i++)
          if (tbl_active[i] && (!any || tbl_expiry[i] < best)) begin
            best = tbl_expiry[i];
            any = 1'b1;
          end
        if (!any) wait_val = 32'hFFFF_FFFF;
        else if (best <= {1'b0, c.now}) wait_val = 32'd0;
        else if (best - {1'b0, c.now} > 49'd2147483647) wait_val = 32'hFFFF_FFFF;
        else wait_val = 32'(best - {1'b0, c.now});
        push_evt(K_WAIT, 4'd0, 1'b0, wait_val, 1'b1);
      end
    endcase
  endfunction

  function automatic void add_cmd(op_t op, logic [3:0] id, logic [31:0] dly, logic rep,
                                  logic [47:0] now);
    timer_cmd_t c;
    c.op = op;
    c.id = id;
    c.delay = dly;
    c.rep = rep;
    c.now = now;
    cmd_queue.push_back(c);
  endfunction

  // random transaction with time mostly moving forward in small steps
  function automatic void add_random_cmd();
    int r;
    logic [31:0] dly;
    op_t op;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_ADD;
    else if (r < 50) op = OP_DEL;
    else if (r < 65) op = OP_RST;
    else op = OP_PROC;
    r = $urandom_range(0, 99);
    if (r < 5) dly = 32'd0;
    else if (r < 8) dly = 32'hFFFF_FFFF;
    else if (r < 14) dly = $urandom;
    else dly = $urandom_range(0, 200);
    if ($urandom_range(0, 99) < 2) sim_now = 48'({$urandom, $urandom});
    else sim_now = sim_now + $urandom_range(0, 50);
    add_cmd(op, 4'($urandom), dly, 1'($urandom), sim_now);
  endfunction

  // driver: offers queued transactions, predicts each one on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_timers(cur_cmd);
        cmd_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() > 0 && !src_hold && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_cmd = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, cur_cmd.now, cur_cmd.rep, cur_cmd.delay, cur_cmd.id,
                       cur_cmd.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, field-by-field comparison
  always @(posedge clk) begin
    timer_evt_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (evt_queue.size() == 0) begin
          $display("%0t: unexpected result tdata=%h tlast=%b", $time, out_tdata,
                   out_tlast);
          errors++;
        end else begin
          e = evt_queue.pop_front();
          if (e.kind == K_FIRE) fired_count++;
          if (e.kind == K_WAIT) wait_count++;
          if (out_tdata[2:0] !== e.kind)
            begin $display("%0t: kind exp %0d got %0d", $time, e.kind, out_tdata[2:0]);
              errors++; end
          if (out_tdata[6:3] !== e.slot)
            begin $display("%0t: slot exp %0d got %0d", $time, e.slot, out_tdata[6:3]);
              errors++; end
          if (out_tdata[7] !== e.status)
            begin $display("%0t: status exp %b got %b", $time, e.status, out_tdata[7]);
              errors++; end
          if (out_tdata[39:8] !== e.wait_ms)
            begin $display("%0t: wait_ms exp %0d got %0d", $time, $signed(e.wait_ms),
                           $signed(out_tdata[39:8])); errors++; end
          if (out_tdata[44:40] !== e.live)
            begin $display("%0t: live exp %0d got %0d", $time, e.live, out_tdata[44:40]);
              errors++; end
          if (out_tlast !== e.last)
            begin $display("%0t: last exp %b got %b", $time, e.last, out_tlast);
              errors++; end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // wait until every queued transaction went in and every result came out
  task automatic drain();
    while (cmd_queue.size() > 0 || in_tvalid || evt_queue.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic run_random(int n, int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (n) add_random_cmd();
    // hold the sender once mid-phase until the table has answered everything
    while (cmd_queue.size() > n / 2) @(posedge clk);
    src_hold = 1'b1;
    while (in_tvalid || evt_queue.size() > 0) @(posedge clk);
    src_hold = 1'b0;
    drain();
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    src_idle_pct = 36;
    sink_idle_pct = 73;
    src_hold = 1'b0;
    sim_now = 48'd100;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty process, fill the table, table full, delete/reset corners
    add_cmd(OP_PROC, 4'd0, 32'd0, 1'b0, 48'd0);
    add_cmd(OP_ADD, 4'd0, 32'd0, 1'b1, 48'd0);          // repeat with zero interval
    add_cmd(OP_ADD, 4'd0, 32'hFFFF_FFFF, 1'b0, 48'd0);  // wait beyond int range
    for (i = 2; i < SLOTS; i++)
      add_cmd(OP_ADD, 4'd0, 32'(i * 3 % 7), 1'(i), 48'd0);
    add_cmd(OP_ADD, 4'd0, 32'd5, 1'b0, 48'd0);          // table full
    add_cmd(OP_DEL, 4'd3, 32'd0, 1'b0, 48'd1);
    add_cmd(OP_DEL, 4'd3, 32'd0, 1'b0, 48'd1);          // delete inactive slot
    add_cmd(OP_RST, 4'd3, 32'd5, 1'b0, 48'd1);          // reset reactivates
    add_cmd(OP_PROC, 4'd0, 32'd0, 1'b0, 48'd4);
    add_cmd(OP_RST, 4'd15, 32'hFFFF_FFFF, 1'b0, 48'hFFFF_FFFF_FFFF);  // expiry carry
    add_cmd(OP_PROC, 4'd0, 32'd0, 1'b0, 48'hFFFF_FFFF_FFFF);
    drain();

    run_random(150, 36, 73);
    run_random(150, 73, 36);
    run_random(150, 0, 0);

    $display("covered %0d transactions: %0d timer firings, %0d wait reports",
             cmd_count, fired_count, wait_count);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/tts_pkg.sv
rtl/core/tts_mem.sv
rtl/core/timer_table_scheduler.sv
tb/sv/tb_timer_table_scheduler.sv
